// ----- src/ippc_pkg.sv -----
package ippc_pkg;

    localparam logic        CMD_COUNT      = 1'b0;
    localparam logic        CMD_READ       = 1'b1;

    localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;

    localparam logic [2:0]  ST_IGNORED     = 3'd0;
    localparam logic [2:0]  ST_HIT         = 3'd1;
    localparam logic [2:0]  ST_NEW         = 3'd2;
    localparam logic [2:0]  ST_FULL        = 3'd3;
    localparam logic [2:0]  ST_READ_VALID  = 3'd4;
    localparam logic [2:0]  ST_READ_EMPTY  = 3'd5;

    localparam logic [63:0] COUNT_MAX      = '1;

    // request token walking the cell chain; carries its own answer
    typedef struct packed {
        logic        cmd;
        logic        done;
        logic [2:0]  status;
        logic [7:0]  slot;
        logic [7:0]  read_index;
        logic [63:0] prefix;
        logic [63:0] count;
    } t_tok;

endpackage

// ----- src/ipv6_prefix_packet_counter.sv -----
// Channel   Direction  Contents
// s_axis    in         tuser: cmd; tdata: ethertype, src_prefix, read_index
// m_axis    out        tuser: status; tdata: slot, prefix, count
//
// One request is in flight at a time. It walks the row of ENTRIES cells, one
// cell per cycle while the chain advances, and from the last cell it passes into
// the output register; the length of the chain sets how long a request takes.
// A new request is taken once the previous one has left the chain, even while
// its result still waits on m_axis. The chain freezes only while a request sits
// in the last cell and the output register holds a result that m_axis has not
// taken. Synchronous active-low reset empties the table (all cell valid bits clear).
module ipv6_prefix_packet_counter
    import ippc_pkg::*;
#(
    parameter int ENTRIES = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [87:0]   s_axis_tdata,  // ethertype[15:0], src_prefix[79:16], read_index[87:80]
    input  logic          s_axis_tuser,  // cmd[0]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [135:0]  m_axis_tdata,  // slot[7:0], prefix[71:8], count[135:72]
    output logic [2:0]    m_axis_tuser   // status[2:0]
);

    logic [ENTRIES:0] w_vld;
    t_tok             w_tok [ENTRIES+1];

    logic             r_busy;
    logic             r_out_vld;
    t_tok             r_out;

    logic             w_adv;
    logic             w_s_acc;
    logic             w_m_acc;
    logic [15:0]      w_ethertype;
    t_tok             w_new;

    // advance the chain unless the last cell holds a result with nowhere to go
    assign w_adv   = !w_vld[ENTRIES] || !r_out_vld || m_axis_tready;
    assign s_axis_tready = !r_busy && w_adv;
    assign w_s_acc = s_axis_tvalid && s_axis_tready;
    assign w_m_acc = m_axis_tvalid && m_axis_tready;

    assign w_ethertype = s_axis_tdata[15:0];

    // Build the token with the answer it gets if no cell claims it: a read of
    // an unoccupied slot, or a full table for a new prefix. Non-IPv6 packets
    // are finished here and only ride along the chain to keep the order.
    always_comb begin
        w_new            = '0;
        w_new.cmd        = s_axis_tuser;
        w_new.read_index = s_axis_tdata[87:80];
        if (s_axis_tuser == CMD_READ) begin
            w_new.status = ST_READ_EMPTY;
            w_new.slot   = s_axis_tdata[87:80];
        end else begin
            w_new.prefix = s_axis_tdata[79:16];
            if (w_ethertype != ETHERTYPE_IPV6) begin
                w_new.done   = 1'b1;
                w_new.status = ST_IGNORED;
            end else begin
                w_new.status = ST_FULL;
            end
        end
    end

    assign w_vld[0] = w_s_acc;
    assign w_tok[0] = w_new;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        ippc_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (w_adv),
            .i_tok_vld (w_vld[g]),
            .i_tok     (w_tok[g]),
            .o_tok_vld (w_vld[g+1]),
            .o_tok     (w_tok[g+1])
        );
    end

    // hold busy from acceptance until the request leaves the last cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_s_acc) begin
                r_busy <= 1'b1;
            end else if (w_vld[ENTRIES] && w_adv) begin
                r_busy <= 1'b0;
            end
            if (w_vld[ENTRIES] && w_adv) begin
                r_out_vld <= 1'b1;
            end else if (w_m_acc) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_vld[ENTRIES] && w_adv) begin
            r_out <= w_tok[ENTRIES];
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = {r_out.count, r_out.prefix, r_out.slot};

`ifndef SYNTHESIS
    // only one request may be inside the chain
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_vld[ENTRIES:1]))
        else $error("more than one request in the cell chain");

    // busy must be high whenever a request is inside the chain
    a_busy_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld[ENTRIES:1] != '0) |-> r_busy)
        else $error("request in chain while not busy");

    // a new entry always starts at one
    a_new_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_NEW)) |-> (m_axis_tdata[135:72] == 64'd1))
        else $error("new entry with count other than one");

    // an empty read reports no prefix and no count
    a_empty_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == ST_READ_EMPTY)) |->
        (m_axis_tdata[135:8] == '0))
        else $error("empty read with data");
`endif

endmodule

// ----- src/ippc_cell.sv -----
module ippc_cell
    import ippc_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_tok_vld,
    input  t_tok i_tok,
    output logic o_tok_vld,
    output t_tok o_tok
);

    localparam logic [7:0] SLOT     = 8'(INDEX % 256);
    localparam logic       READABLE = (INDEX < 256);

    logic        r_vld;
    logic [63:0] r_prefix;
    logic [63:0] r_count;
    logic        r_tok_vld;
    t_tok        r_tok;

    logic        n_vld;
    logic [63:0] n_prefix;
    logic [63:0] n_count;
    t_tok        n_tok;

    logic        w_hit;
    logic [63:0] w_inc;

    assign w_hit = r_vld && (r_prefix == i_tok.prefix);
    assign w_inc = (r_count == COUNT_MAX) ? r_count : r_count + 64'd1;

    always_comb begin
        n_tok    = i_tok;
        n_vld    = r_vld;
        n_prefix = r_prefix;
        n_count  = r_count;
        if (i_tok_vld && !i_tok.done) begin
            if (i_tok.cmd == CMD_COUNT) begin
                if (w_hit) begin
                    n_count      = w_inc;
                    n_tok.done   = 1'b1;
                    n_tok.status = ST_HIT;
                    n_tok.slot   = SLOT;
                    n_tok.count  = w_inc;
                end else if (!r_vld) begin
                    // first free cell: slots fill in order
                    n_vld        = 1'b1;
                    n_prefix     = i_tok.prefix;
                    n_count      = 64'd1;
                    n_tok.done   = 1'b1;
                    n_tok.status = ST_NEW;
                    n_tok.slot   = SLOT;
                    n_tok.count  = 64'd1;
                end
            end else if (READABLE && (i_tok.read_index == SLOT)) begin
                n_tok.done = 1'b1;
                if (r_vld) begin
                    n_tok.status = ST_READ_VALID;
                    n_tok.prefix = r_prefix;
                    n_tok.count  = r_count;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= 1'b0;
            r_tok_vld <= 1'b0;
        end else if (i_en) begin
            r_vld     <= n_vld;
            r_tok_vld <= i_tok_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prefix <= n_prefix;
            r_count  <= n_count;
            r_tok    <= n_tok;
        end
    end

    assign o_tok_vld = r_tok_vld;
    assign o_tok     = r_tok;

endmodule
